// ----- design/fdf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and result-building functions for the frame deframer.
package fdf_pkg;

   // Header layout: byte positions within the five-byte frame header.
   localparam logic [2:0] HDR_POS_VERSION = 3'd0;
   localparam logic [2:0] HDR_POS_TYPE    = 3'd1;
   localparam logic [2:0] HDR_POS_FLAGS   = 3'd2;
   localparam logic [2:0] HDR_POS_LEN_HI  = 3'd3;
   localparam logic [2:0] HDR_POS_LEN_LO  = 3'd4;

   // Fragment header layout: byte offsets within the payload.
   localparam logic [15:0] FRAG_ID_END   = 16'd4;
   localparam logic [15:0] FRAG_IDX_END  = 16'd6;
   localparam logic [15:0] FRAG_TOT_END  = 16'd8;
   localparam logic [15:0] FRAG_HDR_LEN  = 16'd9;
   localparam logic [15:0] MIN_COMP_LEN  = 16'd4;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPRESSED_MASK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAGMENTED_MASK = 2'd2;

   localparam logic [7:0] RST_VERSION         = 8'd1;
   localparam logic [7:0] RST_COMPRESSED_MASK = 8'd1;
   localparam logic [7:0] RST_FRAGMENTED_MASK = 8'd2;

   // Result queue sizing.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_HEADER    = 2'd0,
      KIND_PAYLOAD   = 2'd1,
      KIND_FRAME_END = 2'd2,
      KIND_ERROR     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ERR_INCOMPLETE_HEADER  = 3'd0,
      ERR_INCOMPLETE_PAYLOAD = 3'd1,
      ERR_BAD_VERSION        = 3'd2,
      ERR_SHORT_COMPRESSED   = 3'd3,
      ERR_BAD_FRAGMENT       = 3'd4
   } err_type;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_marker;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [7:0]  frame_flags;
      logic [15:0] payload_length;
      logic [31:0] msg_id;
      logic [15:0] frag_idx;
      logic [15:0] frag_cnt;
      logic [7:0]  orig_ftype;
      err_type     error_code;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] version;
      logic [7:0] compressed_mask;
      logic [7:0] fragmented_mask;
   } cfg_type;

   // Frame header fields as held by the parser.
   typedef struct packed {
      logic [7:0]  frame_type;
      logic [7:0]  frame_flags;
      logic [15:0] payload_length;
   } hdr_type;

   // Captured fragment header.
   typedef struct packed {
      logic [31:0] msg_id;
      logic [15:0] frag_idx;
      logic [15:0] frag_cnt;
      logic [7:0]  orig_ftype;
   } frag_type;

   // Up to two results produced by one request.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic rsp_type make_rsp(kind_type kind, logic [7:0] data, logic hdr_en,
                                        hdr_type hdr, logic frag_en, frag_type frag,
                                        err_type err, logic last);
      rsp_type r;
      r.kind           = kind;
      r.data_byte      = data;
      r.frame_type     = hdr_en ? hdr.frame_type     : 8'd0;
      r.frame_flags    = hdr_en ? hdr.frame_flags    : 8'd0;
      r.payload_length = hdr_en ? hdr.payload_length : 16'd0;
      r.msg_id         = frag_en ? frag.msg_id     : 32'd0;
      r.frag_idx       = frag_en ? frag.frag_idx   : 16'd0;
      r.frag_cnt       = frag_en ? frag.frag_cnt   : 16'd0;
      r.orig_ftype     = frag_en ? frag.orig_ftype : 8'd0;
      r.error_code     = err;
      r.last           = last;
      return r;
   endfunction

   function automatic logic is_compressed(hdr_type hdr, cfg_type cfg);
      return (hdr.frame_flags & cfg.compressed_mask) != 8'd0;
   endfunction

   function automatic logic is_fragmented(hdr_type hdr, cfg_type cfg);
      return !is_compressed(hdr, cfg) && ((hdr.frame_flags & cfg.fragmented_mask) != 8'd0);
   endfunction

   // Closing result of a frame: frame end or the check that failed.
   function automatic rsp_type finish_rsp(hdr_type hdr, frag_type frag, cfg_type cfg);
      rsp_type r;
      if (is_compressed(hdr, cfg) && (hdr.payload_length < MIN_COMP_LEN)) begin
         r = make_rsp(KIND_ERROR, 8'd0, 1'b1, hdr, 1'b0, frag, ERR_SHORT_COMPRESSED, 1'b1);
      end else if (is_fragmented(hdr, cfg) && ((hdr.payload_length < FRAG_HDR_LEN) ||
                   (frag.frag_idx >= frag.frag_cnt))) begin
         r = make_rsp(KIND_ERROR, 8'd0, 1'b1, hdr, 1'b1, frag, ERR_BAD_FRAGMENT, 1'b1);
      end else begin
         r = make_rsp(KIND_FRAME_END, 8'd0, 1'b1, hdr, is_fragmented(hdr, cfg), frag,
                      ERR_INCOMPLETE_HEADER, 1'b1);
      end
      return r;
   endfunction

endpackage

// ----- design/fdf_parser.sv -----
`timescale 1ns / 1ps
// Frame parser: header, payload and fragment-header state with result generation.
module fdf_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  fdf_pkg::req_type  req_data,
   input  fdf_pkg::cfg_type  cfg,
   output fdf_pkg::push_type push
);
   import fdf_pkg::*;

   logic        in_payload_ff, in_payload_in;
   logic [2:0]  header_pos_ff, header_pos_in;
   logic [7:0]  hdr_version_ff, hdr_version_in;
   hdr_type     hdr_ff, hdr_in;
   logic [15:0] payload_count_ff, payload_count_in;
   frag_type    frag_ff, frag_in;

   logic [7:0]  b;
   logic [15:0] count_next;
   hdr_type     hdr_lo;

   always_comb begin
      b                = req_data.byte_value;
      in_payload_in    = in_payload_ff;
      header_pos_in    = header_pos_ff;
      hdr_version_in   = hdr_version_ff;
      hdr_in           = hdr_ff;
      payload_count_in = payload_count_ff;
      frag_in          = frag_ff;
      push             = '0;
      count_next       = payload_count_ff + 16'd1;
      hdr_lo           = hdr_ff;
      hdr_lo.payload_length = {hdr_ff.payload_length[15:8], b};

      if (req_fire) begin
         if (req_data.end_marker) begin
            if (in_payload_ff) begin
               push.count = 2'd1;
               push.first = make_rsp(KIND_ERROR, 8'd0, 1'b1, hdr_ff, 1'b0, frag_ff,
                                     ERR_INCOMPLETE_PAYLOAD, 1'b1);
            end else if (header_pos_ff != HDR_POS_VERSION) begin
               push.count = 2'd1;
               push.first = make_rsp(KIND_ERROR, 8'd0, 1'b0, hdr_ff, 1'b0, frag_ff,
                                     ERR_INCOMPLETE_HEADER, 1'b1);
            end
            in_payload_in    = 1'b0;
            header_pos_in    = HDR_POS_VERSION;
            payload_count_in = 16'd0;
         end else if (!in_payload_ff) begin
            if (header_pos_ff != HDR_POS_LEN_LO) begin
               unique case (header_pos_ff)
                  HDR_POS_VERSION: hdr_version_in = b;
                  HDR_POS_TYPE:    hdr_in.frame_type = b;
                  HDR_POS_FLAGS:   hdr_in.frame_flags = b;
                  default:         hdr_in.payload_length = {b, 8'd0};
               endcase
               header_pos_in = header_pos_ff + 3'd1;
            end else begin
               hdr_in        = hdr_lo;
               header_pos_in = HDR_POS_VERSION;
               if (hdr_version_ff != cfg.version) begin
                  push.count = 2'd1;
                  push.first = make_rsp(KIND_ERROR, 8'd0, 1'b1, hdr_lo, 1'b0, frag_ff,
                                        ERR_BAD_VERSION, 1'b1);
                  payload_count_in = 16'd0;
               end else begin
                  frag_in = '0;
                  payload_count_in = 16'd0;
                  if (hdr_lo.payload_length == 16'd0) begin
                     push.count  = 2'd2;
                     push.first  = make_rsp(KIND_HEADER, 8'd0, 1'b1, hdr_lo, 1'b0, frag_ff,
                                            ERR_INCOMPLETE_HEADER, 1'b0);
                     push.second = finish_rsp(hdr_lo, '0, cfg);
                  end else begin
                     push.count  = 2'd1;
                     push.first  = make_rsp(KIND_HEADER, 8'd0, 1'b1, hdr_lo, 1'b0, frag_ff,
                                            ERR_INCOMPLETE_HEADER, 1'b1);
                     in_payload_in = 1'b1;
                  end
               end
            end
         end else begin
            // Payload byte; the first bytes of a fragmented frame fill the fragment header.
            if (is_fragmented(hdr_ff, cfg) && (payload_count_ff < FRAG_HDR_LEN)) begin
               if (payload_count_ff < FRAG_ID_END) begin
                  frag_in.msg_id = {frag_ff.msg_id[23:0], b};
               end else if (payload_count_ff < FRAG_IDX_END) begin
                  frag_in.frag_idx = {frag_ff.frag_idx[7:0], b};
               end else if (payload_count_ff < FRAG_TOT_END) begin
                  frag_in.frag_cnt = {frag_ff.frag_cnt[7:0], b};
               end else begin
                  frag_in.orig_ftype = b;
               end
            end
            payload_count_in = count_next;
            if (count_next >= hdr_ff.payload_length) begin
               push.count  = 2'd2;
               push.first  = make_rsp(KIND_PAYLOAD, b, 1'b1, hdr_ff, 1'b0, frag_ff,
                                      ERR_INCOMPLETE_HEADER, 1'b0);
               push.second = finish_rsp(hdr_ff, frag_in, cfg);
               in_payload_in    = 1'b0;
               header_pos_in    = HDR_POS_VERSION;
               payload_count_in = 16'd0;
            end else begin
               push.count = 2'd1;
               push.first = make_rsp(KIND_PAYLOAD, b, 1'b1, hdr_ff, 1'b0, frag_ff,
                                     ERR_INCOMPLETE_HEADER, 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff    <= 1'b0;
         header_pos_ff    <= HDR_POS_VERSION;
         hdr_version_ff   <= 8'd0;
         hdr_ff           <= '0;
         payload_count_ff <= 16'd0;
         frag_ff          <= '0;
      end else begin
         in_payload_ff    <= in_payload_in;
         header_pos_ff    <= header_pos_in;
         hdr_version_ff   <= hdr_version_in;
         hdr_ff           <= hdr_in;
         payload_count_ff <= payload_count_in;
         frag_ff          <= frag_in;
      end
   end

endmodule

// ----- design/fdf_rsp_queue.sv -----
`timescale 1ns / 1ps
// Small result queue that takes up to two results per cycle and delivers one while rsp_ready is high.
module fdf_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  fdf_pkg::push_type push,
   output logic              space_ok,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fdf_pkg::rsp_type  rsp_data
);
   import fdf_pkg::*;

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic                   pop;
   logic [RSP_PTR_W-1:0]   wr_ptr_next;

   assign pop         = rsp_valid && rsp_ready;
   assign rsp_valid   = count_ff != '0;
   assign rsp_data    = entry_ff[rd_ptr_ff];
   assign space_ok    = count_ff <= RSP_CNT_W'(RSP_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

endmodule

// ----- design/frame_deframer_unit.sv -----
`timescale 1ns / 1ps
// Top level of the frame deframer: configuration registers, parser and result queue.
//
// The block parses a byte stream of frames (five-byte header of version, type,
// flags and big-endian length, then the payload) and reports header, payload
// byte, frame end and error results.
// Requests arrive on the req_ channel (valid/ready), one stream byte or an end
// marker each. Results leave on the rsp_ channel (valid/ready), one per cycle while
// the receiver is ready. A request produces zero, one or two results; the last flag
// marks the final result of each request.
// Results of an accepted request are registered into the result queue and offered
// on rsp_ in order. Throughput is one request per cycle while each request gives
// at most one result and the receiver is ready; a request giving two results (last
// payload byte or an empty frame) needs a second transfer on the output. The rate
// is set by the single result port draining a four-entry result queue.
// When the receiver stalls, results wait in the queue and requests are still
// taken until fewer than two queue entries are free; req_ready then drops.
// The csr_ port writes the expected version, compressed_mask and
// fragmented_mask at any enabled clock edge; change them only while idle.
// Synchronous reset empties the queue, returns the parser to header byte zero
// and restores the register defaults (1, 1 and 2).
module frame_deframer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  fdf_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fdf_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [fdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                     csr_wdata
);
   import fdf_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   push_type push;
   logic     req_fire;
   logic     space_ok;

   // A request is taken only when the queue can hold both possible results.
   assign req_ready = space_ok;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VERSION:         cfg_in.version         = csr_wdata;
            CSR_COMPRESSED_MASK: cfg_in.compressed_mask = csr_wdata;
            CSR_FRAGMENTED_MASK: cfg_in.fragmented_mask = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version         <= RST_VERSION;
         cfg_ff.compressed_mask <= RST_COMPRESSED_MASK;
         cfg_ff.fragmented_mask <= RST_FRAGMENTED_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The parser holds all frame state and turns each request into results.
   fdf_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .push     (push)
   );

   // The queue decouples the result channel so a stalled receiver does not
   // immediately stop the request side.
   fdf_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- design/fdf_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the frame deframer, bound to the top level.
module fdf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input fdf_pkg::rsp_type rsp_data
);
   import fdf_pkg::*;

   // Nothing is offered in the cycle after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // With no result waiting, the queue has room and a request is never refused.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> req_ready)
      else $error("request refused with an empty result queue");

   // Frame end and error results always close their request.
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_FRAME_END || rsp_data.kind == KIND_ERROR)
      |-> rsp_data.last)
      else $error("frame end or error without last");

   // Only payload results carry a data byte, only errors carry a code.
   a_field_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.kind == KIND_PAYLOAD || rsp_data.data_byte == 8'd0) &&
                    (rsp_data.kind == KIND_ERROR || rsp_data.error_code == ERR_INCOMPLETE_HEADER))
      else $error("unexpected data byte or error code");

endmodule

bind frame_deframer_unit fdf_checker u_fdf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
